>>> sv/b64ld_pkg.sv
// ----------------------------------------------------------------------------
// b64ld_pkg
// Types, character codes and the alphabet lookup for the lenient base64
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64ld_pkg;

    // Character codes that steer decoding
    localparam logic [7:0] C_CHAR_EQ    = 8'h3D;  // '='
    localparam logic [7:0] C_CHAR_LF    = 8'h0A;
    localparam logic [7:0] C_CHAR_CR    = 8'h0D;
    localparam logic [7:0] C_CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] C_CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] C_CHAR_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] C_CHAR_UNDER = 8'h5F;  // '_'
    localparam logic [7:0] C_CHAR_UA    = 8'h41;  // 'A'
    localparam logic [7:0] C_CHAR_UZ    = 8'h5A;  // 'Z'
    localparam logic [7:0] C_CHAR_LA    = 8'h61;  // 'a'
    localparam logic [7:0] C_CHAR_LZ    = 8'h7A;  // 'z'
    localparam logic [7:0] C_CHAR_D0    = 8'h30;  // '0'
    localparam logic [7:0] C_CHAR_D9    = 8'h39;  // '9'

    localparam logic [5:0] C_SEXTET_62  = 6'd62;
    localparam logic [5:0] C_SEXTET_63  = 6'd63;
    localparam logic [7:0] C_LOWER_BASE = 8'd26;
    localparam logic [7:0] C_DIGIT_BASE = 8'd52;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
        logic       terminated;
    } t_out_item;

    typedef struct packed {
        logic       hit;
        logic [5:0] value;
    } t_sextet;

    // Map one character to its 6-bit value; hit is low outside the alphabet.
    function automatic t_sextet sextet_of(input logic [7:0] ch);
        t_sextet    res;
        logic [7:0] off;
        res = '{hit: 1'b1, value: 6'd0};
        off = 8'd0;
        if (ch >= C_CHAR_UA && ch <= C_CHAR_UZ) begin
            off = ch - C_CHAR_UA;
        end else if (ch >= C_CHAR_LA && ch <= C_CHAR_LZ) begin
            off = ch - C_CHAR_LA + C_LOWER_BASE;
        end else if (ch >= C_CHAR_D0 && ch <= C_CHAR_D9) begin
            off = ch - C_CHAR_D0 + C_DIGIT_BASE;
        end else if (ch == C_CHAR_PLUS || ch == C_CHAR_MINUS) begin
            off = {2'b00, C_SEXTET_62};
        end else if (ch == C_CHAR_SLASH || ch == C_CHAR_UNDER) begin
            off = {2'b00, C_SEXTET_63};
        end else begin
            res.hit = 1'b0;
        end
        res.value = off[5:0];
        return res;
    endfunction

endpackage

`default_nettype wire

>>> sv/b64ld_stream_if.sv
// ----------------------------------------------------------------------------
// b64ld_stream_if
// Valid/ready channel carrying one item of a packed payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64ld_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/base64_lenient_decoder.sv
// ----------------------------------------------------------------------------
// base64_lenient_decoder
// Streaming base64 decoder, one character per item, standard and URL-safe
// alphabets, with '=', LF and CR ending decoding of the current message.
// ----------------------------------------------------------------------------
// Takes one character every clock cycle and gives its result in the next cycle
// from an output register; a new character is taken whenever that register is
// empty or is being drained in the same cycle, so the sustained rate is one
// item per cycle while the consumer keeps up. A result appears when a byte
// completes and always on the item flagged end_of_message (byte_valid 0,
// data_byte 0 if no byte completed there). Characters outside the alphabet
// produce nothing, and everything after '=', LF or CR is ignored until the end
// of the message, where leftover bits are dropped and the state clears.
`default_nettype none

module base64_lenient_decoder (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    b64ld_stream_if.sink                        i_in_ch,
    b64ld_stream_if.source                      o_out_ch
);
    import b64ld_pkg::*;

    // Decoder state: last sextet, pending bit count in pairs, stop flag
    logic [5:0] r_last_sextet;
    logic [5:0] n_last_sextet;
    logic [1:0] r_pend;
    logic [1:0] n_pend;
    logic       r_stop;
    logic       n_stop;

    t_out_item  r_out;
    t_out_item  n_out;
    logic       r_out_valid;
    logic       n_out_valid;

    logic       w_in_acc;
    logic       w_is_stop;
    logic       w_take;
    logic       w_byte_valid;
    logic [7:0] w_byte;
    logic       w_emit;
    t_sextet    w_sx;
    t_in_item   w_in;
    logic [11:0] w_cat;

    assign w_in      = i_in_ch.data;
    assign i_in_ch.ready = !r_out_valid || o_out_ch.ready;
    assign w_in_acc  = i_in_ch.valid && i_in_ch.ready;

    assign w_sx      = sextet_of(w_in.in_char);
    assign w_is_stop = (w_in.in_char == C_CHAR_EQ) || (w_in.in_char == C_CHAR_LF)
                    || (w_in.in_char == C_CHAR_CR);
    assign w_take    = !r_stop && !w_is_stop && w_sx.hit;
    assign w_cat     = {r_last_sextet, w_sx.value};
    // A byte completes whenever a sextet is taken while bits are already pending
    assign w_byte_valid = w_take && (r_pend != 2'd0);
    assign w_emit    = w_byte_valid || w_in.end_of_message;

    always_comb begin
        w_byte = 8'd0;
        if (w_byte_valid) begin
            unique case (r_pend)
                2'd1:    w_byte = w_cat[7:0];
                2'd2:    w_byte = w_cat[9:2];
                default: w_byte = w_cat[11:4];
            endcase
        end
    end

    always_comb begin
        n_last_sextet = r_last_sextet;
        n_pend        = r_pend;
        n_stop        = r_stop;
        n_out         = r_out;
        n_out_valid   = r_out_valid && !o_out_ch.ready;
        if (w_in_acc) begin
            if (!r_stop && w_is_stop) begin
                n_stop = 1'b1;
            end
            if (w_take) begin
                n_last_sextet = w_sx.value;
                n_pend        = (r_pend == 2'd0) ? 2'd3 : r_pend - 2'd1;
            end
            if (w_in.end_of_message) begin
                n_last_sextet = 6'd0;
                n_pend        = 2'd0;
                n_stop        = 1'b0;
            end
            if (w_emit) begin
                n_out_valid      = 1'b1;
                n_out.data_byte  = w_byte;
                n_out.byte_valid = w_byte_valid;
                n_out.last       = w_in.end_of_message;
                n_out.terminated = r_stop || w_is_stop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sextet <= 6'd0;
            r_pend        <= 2'd0;
            r_stop        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_last_sextet <= n_last_sextet;
            r_pend        <= n_pend;
            r_stop        <= n_stop;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;

    // A result without a byte only closes a message
    a_empty_result_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.byte_valid || r_out.last))
        else $error("result without byte and without last");

    // An empty result carries a zero byte
    a_empty_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.byte_valid) |-> (r_out.data_byte == 8'd0))
        else $error("nonzero data_byte on result without byte");

    // Ending a message clears the decoder state
    a_eom_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_in.end_of_message) |=>
            (r_pend == 2'd0 && !r_stop && r_last_sextet == 6'd0))
        else $error("state not cleared after end of message");

    // Nothing is decoded once a stop character has been seen
    a_stop_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_stop && !w_in.end_of_message) |=>
            ($stable(r_pend) && $stable(r_last_sextet) && r_stop))
        else $error("decoding continued after stop character");

endmodule

`default_nettype wire
